// ===== design/tcw_pkg.sv =====
// Shared types and constants of the text console writer.
`default_nettype none

package tcw_pkg;

   // Field widths fixed by the interface
   localparam int CODE_W    = 8;
   localparam int ADDR_W    = 11;
   localparam int CELL_W    = 16;
   localparam int ROW_OUT_W = 5;
   localparam int COL_OUT_W = 7;
   localparam int COLOR_W   = 8;

   // Command codes
   localparam logic CMD_PUT  = 1'b0;
   localparam logic CMD_READ = 1'b1;

   // Character and cell codes
   localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'd10;
   localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;

   // Configuration register map
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] REG_TEXT_COLOR    = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SCROLL_ENABLE = 1'd1;
   localparam logic [COLOR_W-1:0]     COLOR_RESET       = 8'd7;
   localparam logic                   SCROLL_RESET      = 1'b1;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Classified operation
   typedef enum logic [1:0] {
      OP_PUT,
      OP_NEWLINE,
      OP_READ,
      OP_READ_NONE
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [CODE_W-1:0]   code;
      logic [ADDR_W-1:0]   addr;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

   // Back-end sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_SHIFT,
      ST_DRAIN,
      ST_BLANK
   } state_type;

endpackage

`default_nettype wire

// ===== design/tcw_front.sv =====
// Front end: accepts commands, classifies them and queues them for the back end.
`default_nettype none

module tcw_front
   import tcw_pkg::*;
#(
   parameter int CELL_COUNT = 2000
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic                req_cmd,
   input  wire logic [CODE_W-1:0]   req_char_code,
   input  wire logic [ADDR_W-1:0]   req_cell_address,
   input  wire logic                clearing,
   input  wire logic                pop,
   output queue_head_type           head
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type               slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   item_type               item_c;
   logic                   push;
   logic                   full;

   // Classify the incoming transaction
   always_comb begin
      item_c.code = req_char_code;
      item_c.addr = req_cell_address;
      if (req_cmd == CMD_READ) begin
         item_c.op = (32'(req_cell_address) < CELL_COUNT) ? OP_READ : OP_READ_NONE;
      end else if (req_char_code == NEWLINE_CODE) begin
         item_c.op = OP_NEWLINE;
      end else begin
         item_c.op = OP_PUT;
      end
   end

   // Hold off new transactions while the queue is full or the screen is clearing
   assign full = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign busy = full | clearing;
   assign push = start & ~busy;

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store queued items
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= item_c;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.item  = slot_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// ===== design/tcw_back.sv =====
// Back end: screen memory, cursor, scroll and clear sequencer, and result register.
`default_nettype none

module tcw_back
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire queue_head_type         head,
   output logic                        pop,
   output logic                        clearing,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [COLOR_W-1:0]     csr_write_data,
   output logic                        rsp_valid,
   output logic [CELL_W-1:0]           rsp_cell_value,
   output logic [ROW_OUT_W-1:0]        rsp_cursor_row,
   output logic [COL_OUT_W-1:0]        rsp_cursor_column,
   output logic                        rsp_scrolled
);

   localparam int CELL_COUNT = ROWS * COLUMNS;
   localparam int AW = $clog2(CELL_COUNT);
   localparam int RW = $clog2(ROWS);
   localparam int CW = $clog2(COLUMNS);
   localparam logic [AW-1:0] COLS_AW       = AW'(COLUMNS);
   localparam logic [AW-1:0] LAST_CELL     = AW'(CELL_COUNT - 1);
   localparam logic [AW-1:0] LAST_ROW_BASE = AW'((ROWS - 1) * COLUMNS);
   localparam logic [RW-1:0] LAST_ROW      = RW'(ROWS - 1);
   localparam logic [CW-1:0] LAST_COL      = CW'(COLUMNS - 1);

   // Screen memory
   logic [CELL_W-1:0]   screen_mem [CELL_COUNT];
   logic [CELL_W-1:0]   mem_rdata_ff;
   logic                mem_we;
   logic [AW-1:0]       mem_waddr;
   logic [AW-1:0]       mem_raddr;
   logic [CELL_W-1:0]   mem_wdata;

   // Control and cursor state
   state_type           state_ff, state_in;
   logic [RW-1:0]       row_ff, row_in;
   logic [CW-1:0]       col_ff, col_in;
   logic [AW-1:0]       ptr_ff, ptr_in;
   logic [AW-1:0]       wptr_ff, wptr_in;
   logic                wvld_ff, wvld_in;
   logic [COLOR_W-1:0]  color_ff;
   logic                scroll_en_ff;

   // Result register
   logic                rsp_valid_ff;
   logic [CELL_W-1:0]   rsp_value_ff;
   logic [ROW_OUT_W-1:0] rsp_row_ff;
   logic [COL_OUT_W-1:0] rsp_col_ff;
   logic                rsp_scrolled_ff;
   logic                emit;
   logic [CELL_W-1:0]   emit_value;
   logic                emit_scrolled;

   logic                at_last_col;
   logic                at_last_row;
   logic                adv_row;
   logic                scroll_go;
   logic                ptr_last;
   logic [AW-1:0]       put_addr;

   // Classify the cursor move of the queued command
   assign at_last_col = (col_ff == LAST_COL);
   assign at_last_row = (row_ff == LAST_ROW);
   assign adv_row     = (head.item.op == OP_NEWLINE) ||
                        ((head.item.op == OP_PUT) && at_last_col);
   assign scroll_go   = adv_row & at_last_row & scroll_en_ff;
   assign ptr_last    = (ptr_ff == LAST_CELL);
   assign put_addr    = AW'(row_ff) * COLS_AW + AW'(col_ff);
   assign clearing    = (state_ff == ST_CLEAR);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (ptr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (head.valid) begin
               if (head.item.op == OP_READ) begin
                  state_in = ST_READ;
               end else if (scroll_go) begin
                  state_in = ST_SHIFT;
               end
            end
         end
         ST_READ:  state_in = ST_IDLE;
         ST_SHIFT: begin
            if (ptr_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: state_in = ST_BLANK;
         ST_BLANK: begin
            if (ptr_last) state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // Outputs: memory access, cursor update, pop and result
   always_comb begin
      pop           = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = ptr_ff;
      mem_wdata     = BLANK_CELL;
      mem_raddr     = ptr_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      ptr_in        = ptr_ff;
      wptr_in       = wptr_ff;
      wvld_in       = wvld_ff;
      emit          = 1'b0;
      emit_value    = '0;
      emit_scrolled = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            ptr_in = ptr_ff + 1'b1;
         end
         ST_IDLE: begin
            if (head.valid) begin
               pop = 1'b1;
               case (head.item.op)
                  OP_READ: begin
                     mem_raddr = AW'(head.item.addr);
                  end
                  OP_READ_NONE: begin
                     emit = 1'b1;
                  end
                  default: begin
                     // put or newline
                     if (head.item.op == OP_PUT) begin
                        mem_we    = 1'b1;
                        mem_waddr = put_addr;
                        mem_wdata = {color_ff, head.item.code};
                     end
                     if (!adv_row) begin
                        col_in = col_ff + 1'b1;
                        emit   = 1'b1;
                     end else begin
                        col_in = '0;
                        if (!at_last_row) begin
                           row_in = row_ff + 1'b1;
                           emit   = 1'b1;
                        end else if (scroll_en_ff) begin
                           ptr_in  = COLS_AW;
                           wvld_in = 1'b0;
                        end else begin
                           row_in = '0;
                           emit   = 1'b1;
                        end
                     end
                  end
               endcase
            end
         end
         ST_READ: begin
            emit       = 1'b1;
            emit_value = mem_rdata_ff;
         end
         ST_SHIFT: begin
            // read one row ahead, write the cell fetched last cycle
            mem_we    = wvld_ff;
            mem_waddr = wptr_ff;
            mem_wdata = mem_rdata_ff;
            wvld_in   = 1'b1;
            wptr_in   = ptr_ff - COLS_AW;
            ptr_in    = ptr_ff + 1'b1;
         end
         ST_DRAIN: begin
            mem_we    = 1'b1;
            mem_waddr = wptr_ff;
            mem_wdata = mem_rdata_ff;
            ptr_in    = LAST_ROW_BASE;
         end
         ST_BLANK: begin
            mem_we = 1'b1;
            if (ptr_last) begin
               emit          = 1'b1;
               emit_scrolled = 1'b1;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         row_ff       <= '0;
         col_ff       <= '0;
         ptr_ff       <= '0;
         wvld_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         ptr_ff       <= ptr_in;
         wvld_ff      <= wvld_in;
         rsp_valid_ff <= emit;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         color_ff     <= COLOR_RESET;
         scroll_en_ff <= SCROLL_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_TEXT_COLOR:    color_ff     <= csr_write_data;
            REG_SCROLL_ENABLE: scroll_en_ff <= csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      wptr_ff <= wptr_in;
      if (emit) begin
         rsp_value_ff    <= emit_value;
         rsp_row_ff      <= ROW_OUT_W'(row_in);
         rsp_col_ff      <= COL_OUT_W'(col_in);
         rsp_scrolled_ff <= emit_scrolled;
      end
   end

   // Screen memory port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         screen_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= screen_mem[mem_raddr];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cell_value    = rsp_value_ff;
   assign rsp_cursor_row    = rsp_row_ff;
   assign rsp_cursor_column = rsp_col_ff;
   assign rsp_scrolled      = rsp_scrolled_ff;

endmodule

`default_nettype wire

// ===== design/text_console_writer.sv =====
// Top level of the text console writer.
//
// Character-cell screen of ROWS x COLUMNS cells with a write cursor. A command is
// taken when start is high and busy is low; each command returns exactly one result,
// shown for one cycle with rsp_valid high, and the receiver cannot stall it. Commands
// pass through a two-entry queue into a sequencer that owns a screen memory with one
// write port and one registered read port (one write and one read per cycle). A put or
// newline without scroll gives its result from the idle state, a read after the
// registered memory read, and a put or newline that scrolls after the shift, drain and
// blank states, since every cell is moved or blanked through the memory port, one per
// cycle. After reset busy stays high while the memory is cleared to blank cells;
// configuration writes are taken at any time.
`default_nettype none

module text_console_writer
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic                   req_cmd,
   input  wire logic [CODE_W-1:0]      req_char_code,
   input  wire logic [ADDR_W-1:0]      req_cell_address,
   output logic                        rsp_valid,
   output logic [CELL_W-1:0]           rsp_cell_value,
   output logic [ROW_OUT_W-1:0]        rsp_cursor_row,
   output logic [COL_OUT_W-1:0]        rsp_cursor_column,
   output logic                        rsp_scrolled,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [COLOR_W-1:0]     csr_write_data
);

   queue_head_type head;
   logic           pop;
   logic           clearing;

   // Accept and classify
   tcw_front #(
      .CELL_COUNT (ROWS * COLUMNS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cmd          (req_cmd),
      .req_char_code    (req_char_code),
      .req_cell_address (req_cell_address),
      .clearing         (clearing),
      .pop              (pop),
      .head             (head)
   );

   // Execute against the screen
   tcw_back #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .pop               (pop),
      .clearing          (clearing),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_cell_value    (rsp_cell_value),
      .rsp_cursor_row    (rsp_cursor_row),
      .rsp_cursor_column (rsp_cursor_column),
      .rsp_scrolled      (rsp_scrolled)
   );

endmodule

`default_nettype wire

// ===== design/tcw_checker.sv =====
// Port-level assertions for the text console writer, bound to the top level.
`default_nettype none

module tcw_port_checker
   import tcw_pkg::*;
#(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   busy,
   input wire logic                   rsp_valid,
   input wire logic [CELL_W-1:0]      rsp_cell_value,
   input wire logic [ROW_OUT_W-1:0]   rsp_cursor_row,
   input wire logic [COL_OUT_W-1:0]   rsp_cursor_column,
   input wire logic                   rsp_scrolled
);

   // Clearing pass holds off transactions right after reset
   a_busy_after_reset: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low right after reset");

   // No result without a transaction behind it
   a_no_rsp_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result strobe right after reset");

   // A scroll leaves the cursor at the start of the bottom row
   a_scroll_cursor: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_scrolled) |->
         (rsp_cursor_row == ROW_OUT_W'(ROWS - 1)) && (rsp_cursor_column == '0))
      else $error("scroll result with wrong cursor");

   // A scroll comes from a put or newline, which reads no cell
   a_scroll_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_scrolled) |-> (rsp_cell_value == '0))
      else $error("scroll result with nonzero cell value");

endmodule

bind text_console_writer tcw_port_checker #(
   .COLUMNS (COLUMNS),
   .ROWS    (ROWS)
) u_checker (.*);

`default_nettype wire
